// ===== hw/rtl/pfae_pkg.sv =====
// ----------------------------------------------------------------------------
// pfae_pkg
// Request codes, field widths and character constants of the frame encoder.
// ----------------------------------------------------------------------------
package pfae_pkg;

    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int GRP_W  = 6;
    localparam int OUSER_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_DATA = 2'd0,
        REQ_LEAD = 2'd1,
        REQ_END  = 2'd2
    } req_t;

    localparam logic [BYTE_W-1:0] GROUP_BIAS = 8'h30;
    localparam logic [GRP_W-1:0]  GROUP_ONES = 6'h3F;

endpackage

// ===== hw/rtl/parity_frame_ascii_encoder_core.sv =====
// ----------------------------------------------------------------------------
// parity_frame_ascii_encoder_core
// Turns data bytes, lead-in requests and end marks into output characters.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request beat, tuser = request kind, tdata = data byte.
//   m_ channel: one character beat, tdata = character, tlast marks the final
//   beat caused by a request, tuser carries the line feed and has-char flags.
//   cfg_we/cfg_wdata set the output mode (0 binary, 1 six-bit ASCII groups);
//   write it only while the block is idle.
//   An accepted request is registered in the expansion stage, which feeds
//   the output register. One result beat leaves per cycle from the output
//   register while m_tready is high, and a request holds the expansion stage
//   until its last result has moved on: one for a binary byte, two for an
//   ASCII byte, LEAD_IN_GROUPS for a lead-in in ASCII mode. The next request
//   is taken in the cycle the current one's last result moves out.
//   Reset clears the column, the mode and both stages.
//   When m_tready is low the output register holds its beat, the expansion
//   stage stops on a request with results and s_tready drops while it waits.
// ----------------------------------------------------------------------------
module parity_frame_ascii_encoder_core #(
    parameter int LEAD_IN_GROUPS = 64,
    parameter int LINE_WIDTH     = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfae_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [pfae_pkg::REQ_W-1:0]    s_tuser,   // [1:0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfae_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_char
    output logic [pfae_pkg::OUSER_W-1:0]  m_tuser,   // [0] newline_before,
                                                     // [1] has_char,
                                                     // [2] newline_after
    output logic                          m_tlast
);
    import pfae_pkg::*;

    localparam int IDX_W = $clog2(LEAD_IN_GROUPS + 1);
    localparam logic [IDX_W-1:0] LEAD_LAST = IDX_W'(LEAD_IN_GROUPS - 1);
    localparam logic [COL_W:0]   WIDTH_C   = (COL_W + 1)'(LINE_WIDTH);

    logic                 mode_reg;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [REQ_W-1:0]     cur_type_reg;
    logic [BYTE_W-1:0]    cur_byte_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]    m_data_reg;
    logic [OUSER_W-1:0]   m_user_reg;
    logic                 m_last_reg;

    logic                 out_load, step, no_res, res_last;
    logic                 res_nlb, res_has, res_nla;
    logic [BYTE_W-1:0]    res_char;
    logic [COL_W-1:0]     col_base, res_col;
    logic                 adv_en;
    logic [COL_W:0]       col_inc;
    logic [11:0]          frame;
    logic                 s_acc;

    assign frame    = {2'b11, ^cur_byte_reg, cur_byte_reg, 1'b0};
    assign out_load = !m_valid_reg || m_tready;

    always_comb begin
        no_res   = 1'b0;
        res_last = 1'b1;
        res_nlb  = 1'b0;
        res_has  = 1'b1;
        res_char = cur_byte_reg;
        adv_en   = 1'b0;
        col_base = col_reg;
        case (cur_type_reg)
            REQ_DATA: begin
                if (mode_reg) begin
                    adv_en   = 1'b1;
                    res_last = (idx_reg == IDX_W'(1));
                    res_char = res_last ? ({2'b00, frame[11:6]} + GROUP_BIAS)
                                        : ({2'b00, frame[5:0]} + GROUP_BIAS);
                end
            end
            REQ_LEAD: begin
                no_res   = !mode_reg;
                adv_en   = 1'b1;
                res_last = (idx_reg == LEAD_LAST);
                res_char = {2'b00, GROUP_ONES} + GROUP_BIAS;
                if (idx_reg == '0) begin
                    res_nlb  = (col_reg != '0);
                    col_base = '0;
                end
            end
            REQ_END: begin
                no_res   = !mode_reg || (col_reg == '0);
                res_nlb  = 1'b1;
                res_has  = 1'b0;
                res_char = '0;
                col_base = '0;
            end
            default: begin
                no_res = 1'b1;
            end
        endcase
        col_inc = {1'b0, col_base} + (COL_W + 1)'(1);
        res_nla = 1'b0;
        res_col = col_base;
        if (adv_en) begin
            if (col_inc >= WIDTH_C) begin
                res_nla = 1'b1;
                res_col = '0;
            end else begin
                res_col = col_inc[COL_W-1:0];
            end
        end
    end

    assign step     = cur_valid_reg && (no_res || out_load);
    assign s_tready = !cur_valid_reg || (step && (no_res || res_last));
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        m_valid_next   = m_valid_reg;
        if (step) begin
            idx_next = idx_reg + IDX_W'(1);
            if (!no_res) begin
                col_next = res_col;
            end
            if (no_res || res_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (s_acc) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        if (out_load) begin
            m_valid_next = step && !no_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            col_reg       <= '0;
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            col_reg       <= col_next;
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cur_type_reg <= s_tuser;
            cur_byte_reg <= s_tdata;
        end
        if (out_load && step && !no_res) begin
            m_data_reg <= res_char;
            m_user_reg <= {res_nla, res_has, res_nlb};
            m_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < WIDTH_C)
        else $error("column beyond line width");

    a_nl_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_user_reg[1]) |-> (m_user_reg[0] && m_last_reg
            && m_data_reg == '0 && !m_user_reg[2]))
        else $error("malformed newline-only beat");

    a_binary_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !mode_reg) |-> (m_last_reg && m_user_reg[1]
            && !m_user_reg[0] && !m_user_reg[2]))
        else $error("binary beat not a single plain character");

    a_wrap_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && step && !no_res && res_nla) |=> (col_reg == '0))
        else $error("column not cleared after full line");

endmodule

// ===== dv/tb_parity_frame_ascii_encoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_parity_frame_ascii_encoder_core
// Self-checking bench for the parity frame encoder: a directed table, then
// random request streams in both output modes with random stalls on both
// channels, checked beat by beat against a behavioral character predictor.
// ----------------------------------------------------------------------------
module tb_parity_frame_ascii_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pfae_pkg::*;

    localparam int LEAD_GROUPS = 64;
    localparam int LINE_W      = 64;
    localparam int N_RAND      = 310;
    localparam int SETTLE      = 4;
    localparam int HOLD_CYC    = 400;
    localparam int TIMEOUT_NS  = 50_000_000;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;   // unused request code

    localparam logic OMODE_RAW = 1'b0;
    localparam logic OMODE_GRP = 1'b1;

    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_NONE  = 2'd1;
    localparam logic [1:0] CHK_ONE   = 2'd2;

    typedef struct packed {
        logic              nl_pre;
        logic              has_ch;
        logic [BYTE_W-1:0] ch;
        logic              nl_post;
        logic              tail;
    } beat_t;

    typedef struct packed {
        logic              mode;
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] d;
        logic [1:0]        chk;
        beat_t             want;
    } drow_t;

    localparam beat_t LF_ONLY = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

    localparam int N_DIR = 22;
    localparam drow_t DIR_TAB [N_DIR] = '{
        '{OMODE_RAW, REQ_DATA, 8'h00, CHK_ONE,   '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1}},
        '{OMODE_RAW, REQ_DATA, 8'hFF, CHK_ONE,   '{1'b0, 1'b1, 8'hFF, 1'b0, 1'b1}},
        '{OMODE_RAW, REQ_DATA, 8'h5A, CHK_ONE,   '{1'b0, 1'b1, 8'h5A, 1'b0, 1'b1}},
        '{OMODE_RAW, REQ_LEAD, 8'h00, CHK_NONE,  '0},
        '{OMODE_RAW, REQ_END,  8'h00, CHK_NONE,  '0},
        '{OMODE_RAW, REQ_NONE, 8'hA5, CHK_NONE,  '0},
        '{OMODE_RAW, REQ_DATA, 8'h81, CHK_ONE,   '{1'b0, 1'b1, 8'h81, 1'b0, 1'b1}},
        '{OMODE_GRP, REQ_END,  8'h00, CHK_NONE,  '0},
        '{OMODE_GRP, REQ_DATA, 8'h00, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_DATA, 8'hFF, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_DATA, 8'h01, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_DATA, 8'h80, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_NONE, 8'h7E, CHK_NONE,  '0},
        '{OMODE_GRP, REQ_END,  8'h00, CHK_ONE,   LF_ONLY},
        '{OMODE_GRP, REQ_LEAD, 8'h00, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_END,  8'hFF, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_DATA, 8'h5A, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_LEAD, 8'h00, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_DATA, 8'hC3, CHK_MODEL, '0},
        '{OMODE_GRP, REQ_END,  8'h00, CHK_ONE,   LF_ONLY},
        '{OMODE_RAW, REQ_DATA, 8'h3C, CHK_ONE,   '{1'b0, 1'b1, 8'h3C, 1'b0, 1'b1}},
        '{OMODE_RAW, REQ_DATA, 8'hC0, CHK_ONE,   '{1'b0, 1'b1, 8'hC0, 1'b0, 1'b1}}
    };

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata   = '0;
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic [OUSER_W-1:0]  m_tuser;
    logic                m_tlast;

    logic                hold_rx   = 1'b0;
    logic                tx_burst  = 1'b0;

    // predictor state
    logic                mode_sh   = 1'b0;
    logic [COL_W-1:0]    col_cnt   = '0;

    beat_t               char_q [$];
    int                  err_cnt   = 0;
    int                  n_acc     = 0;
    int                  rnd_cnt   = 0;

    parity_frame_ascii_encoder_core #(
        .LEAD_IN_GROUPS (LEAD_GROUPS),
        .LINE_WIDTH     (LINE_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic col_step();
        if (col_cnt + 1 >= LINE_W) begin
            col_cnt = '0;
            return 1'b1;
        end
        col_cnt = col_cnt + 1'b1;
        return 1'b0;
    endfunction

    // characters caused by one request, updating mode-dependent column state
    function automatic void encode_chars(input logic [REQ_W-1:0] req,
                                         input logic [BYTE_W-1:0] d,
                                         ref beat_t res [$]);
        logic [11:0] frame;
        logic        nl_first;
        beat_t       b;
        res = {};
        if (req == REQ_NONE) return;
        if (mode_sh == OMODE_RAW) begin
            if (req == REQ_DATA) res.push_back('{1'b0, 1'b1, d, 1'b0, 1'b1});
            return;
        end
        case (req)
            REQ_DATA: begin
                frame     = {2'b11, ^d, d, 1'b0};
                b         = '{1'b0, 1'b1, GROUP_BIAS + {2'b00, frame[5:0]}, 1'b0, 1'b0};
                b.nl_post = col_step();
                res.push_back(b);
                b.ch      = GROUP_BIAS + {2'b00, frame[11:6]};
                b.nl_post = col_step();
                b.tail    = 1'b1;
                res.push_back(b);
            end
            REQ_LEAD: begin
                nl_first = (col_cnt != 0);
                col_cnt  = '0;
                for (int i = 0; i < LEAD_GROUPS; i++) begin
                    b         = '{1'b0, 1'b1, GROUP_BIAS + {2'b00, GROUP_ONES}, 1'b0, 1'b0};
                    b.nl_pre  = (i == 0) && nl_first;
                    b.nl_post = col_step();
                    b.tail    = (i == LEAD_GROUPS - 1);
                    res.push_back(b);
                end
            end
            REQ_END: begin
                if (col_cnt != 0) begin
                    col_cnt = '0;
                    res.push_back(LF_ONLY);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic pause_tx(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] d,
                            input logic [1:0] chk, input beat_t want);
        beat_t res [$];
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        rnd_cnt++;
        encode_chars(req, d, res);
        if (chk == CHK_MODEL) begin
            foreach (res[i]) char_q.push_back(res[i]);
        end else if (chk == CHK_ONE) begin
            char_q.push_back(want);
        end
        n_acc++;
        if (!tx_burst && $urandom_range(0, 1)) pause_tx(idle_len());
    endtask

    task automatic put(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] d);
        send_req(req, d, CHK_MODEL, '0);
    endtask

    // drain all expected characters, then let a trailing no-output request retire
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_sh    = m;
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic bin_item();
        if ($urandom_range(0, 9) < 7) put(REQ_DATA, rand_byte());
        else put(REQ_W'($urandom_range(1, 3)), rand_byte());
    endtask

    task automatic ascii_seq();
        int n;
        if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 9) < 7) put(REQ_LEAD, rand_byte());
            n = $urandom_range(1, 40);
            repeat (n) put(REQ_DATA, rand_byte());
            if ($urandom_range(0, 9) < 8) put(REQ_END, rand_byte());
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) put(REQ_W'($urandom_range(0, 3)), rand_byte());
        end
    endtask

    initial begin : stim
        int mode_now;
        int ph_end;
        mode_now = -1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_TAB[i]) begin
            if (mode_now != int'(DIR_TAB[i].mode)) begin
                set_mode(DIR_TAB[i].mode);
                mode_now = int'(DIR_TAB[i].mode);
            end
            send_req(DIR_TAB[i].req, DIR_TAB[i].d, DIR_TAB[i].chk, DIR_TAB[i].want);
        end

        // each phase boundary also pauses the sender until all characters are out
        rnd_cnt = 0;
        for (int ph = 0; rnd_cnt < N_RAND; ph++) begin
            set_mode((ph % 3 == 1) ? OMODE_RAW : OMODE_GRP);
            tx_burst = ($urandom_range(0, 3) == 0);
            ph_end   = rnd_cnt + ((mode_sh == OMODE_GRP) ? 80 : 30);
            while (rnd_cnt < ph_end) begin
                if (mode_sh == OMODE_GRP) ascii_seq();
                else bin_item();
            end
        end

        wait_idle();
        if (err_cnt == 0 && char_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : rx_hold
        wait (n_acc >= N_DIR + 30);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYC) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin : rx_pace
        int stall_left;
        int quiet_left;
        stall_left = 0;
        quiet_left = 0;
        forever begin
            @(posedge aclk);
            if (quiet_left > 0) quiet_left--;
            if (hold_rx) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (quiet_left == 0) begin
                    if ($urandom_range(0, 99) < 3) quiet_left = $urandom_range(50, 200);
                    else if ($urandom_range(0, 99) < 30) stall_left = idle_len();
                end
            end
        end
    end

    task automatic flag(input string what, input beat_t want, input beat_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display({"%0t %s: exp nlb=%0b chr=%0b data=%02h nla=%0b last=%0b,",
                      " got nlb=%0b chr=%0b data=%02h nla=%0b last=%0b"},
                     $realtime, what, want.nl_pre, want.has_ch, want.ch,
                     want.nl_post, want.tail,
                     got.nl_pre, got.has_ch, got.ch, got.nl_post, got.tail);
    endtask

    always @(posedge aclk) begin : char_check
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tuser[1], m_tdata, m_tuser[2], m_tlast};
            if (char_q.size() == 0) begin
                flag("unexpected beat", '0, got);
            end else begin
                want = char_q.pop_front();
                if (got.nl_pre !== want.nl_pre || got.has_ch !== want.has_ch
                    || got.ch !== want.ch || got.nl_post !== want.nl_post
                    || got.tail !== want.tail)
                    flag("mismatch", want, got);
            end
        end
    end

endmodule
